// File: hdl/sm4_pkg.sv
// SM4 engine package: opcodes, state type, S-box and round function.
package sm4_pkg;

    localparam int ROUNDS_DEF = 32;
    localparam int KEY_W      = 32;
    localparam int BLOCK_W    = 128;
    localparam int TDATA_W    = 168;

    typedef enum logic [1:0] {
        OP_KEY_WR  = 2'd0,
        OP_ENCRYPT = 2'd1,
        OP_DECRYPT = 2'd2,
        OP_NONE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROUND,
        ST_OUT
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] tbl [256];
        tbl = '{
            8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,
            8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
            8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,
            8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
            8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,
            8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
            8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,
            8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
            8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,
            8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
            8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,
            8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
            8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,
            8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
            8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,
            8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
            8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,
            8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
            8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,
            8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
            8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,
            8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
            8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,
            8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
            8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,
            8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
            8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,
            8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
            8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,
            8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
            8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,
            8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
        };
        return tbl[a];
    endfunction

    function automatic logic [31:0] round_t(input logic [31:0] a);
        logic [31:0] b;
        b = {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
        return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                 ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

endpackage

// File: hdl/sm4_ram.sv
// Generic single-port-write RAM with registered read.
module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/sm4_block_cipher_top.sv
// SM4 engine top level: key store, round sequencer and output register.
// Key write: accepted in ST_IDLE, no result.
// Encrypt/decrypt: one round per cycle through the shared round unit; result is
// held until taken, and no new transfer is accepted until it has been taken.
// Key store read port is registered, so each key is fetched in the cycle before its round.
// Synchronous active-low reset clears the sequencer; round keys are unknown until written.
module sm4_block_cipher_top
    import sm4_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // opcode[1:0], key_index[6:2], key_word[38:7], block_hi[102:39],
    // block_lo[166:103], zero fill
    input  logic [TDATA_W-1:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // result_hi[63:0], result_lo[127:64]
    output logic [BLOCK_W-1:0] m_axis_tdata
);
    localparam int CW = $clog2(ROUNDS);

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_dec, n_dec;
    logic [31:0]    r_x0, r_x1, r_x2, r_x3;
    logic [31:0]    n_x0, n_x1, n_x2, n_x3;
    logic [CW-1:0]  w_raddr;
    logic [31:0]    w_rk;
    logic [31:0]    w_nx;

    t_opcode        w_op;
    logic           w_xfer;

    assign w_op   = t_opcode'(s_axis_tdata[1:0]);
    assign w_xfer = s_axis_tvalid && s_axis_tready;

    sm4_ram #(.WIDTH(KEY_W), .DEPTH(ROUNDS)) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_xfer && w_op == OP_KEY_WR),
        .i_waddr(s_axis_tdata[2 +: CW]),
        .i_wdata(s_axis_tdata[7 +: KEY_W]),
        .i_raddr(w_raddr),
        .o_rdata(w_rk)
    );

    assign w_nx = r_x0 ^ round_t(r_x1 ^ r_x2 ^ r_x3 ^ w_rk);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_dec   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dec   <= n_dec;
        end
        r_x0 <= n_x0;
        r_x1 <= n_x1;
        r_x2 <= n_x2;
        r_x3 <= n_x3;
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_dec   = r_dec;
        n_x0    = r_x0;
        n_x1    = r_x1;
        n_x2    = r_x2;
        n_x3    = r_x3;
        w_raddr = r_dec ? CW'(ROUNDS - 1) - r_cnt : r_cnt;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_xfer && (w_op == OP_ENCRYPT || w_op == OP_DECRYPT)) begin
                    n_dec   = (w_op == OP_DECRYPT);
                    n_cnt   = '0;
                    n_x0    = s_axis_tdata[102:71];
                    n_x1    = s_axis_tdata[39+:32];
                    n_x2    = s_axis_tdata[166:135];
                    n_x3    = s_axis_tdata[103+:32];
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_ROUND;
                n_cnt   = r_cnt + 1'b1;
            end
            ST_ROUND: begin
                n_x0 = r_x1;
                n_x1 = r_x2;
                n_x2 = r_x3;
                n_x3 = w_nx;
                if (r_cnt == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign m_axis_tdata = {r_x1, r_x0, r_x3, r_x2};
endmodule

// File: hdl/sm4_checker.sv
// Port checker for the SM4 engine, bound to the top level.
module sm4_checker
    import sm4_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [TDATA_W-1:0] s_axis_tdata,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [BLOCK_W-1:0] m_axis_tdata
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken during output");
    a_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready &&
        (s_axis_tdata[1:0] == OP_ENCRYPT || s_axis_tdata[1:0] == OP_DECRYPT)
        |=> !s_axis_tready && !m_axis_tvalid) else $error("block not started");
    a_key_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tdata[1:0] == OP_KEY_WR
        |=> s_axis_tready) else $error("key write stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
endmodule

bind sm4_block_cipher_top sm4_checker u_chk (.*);
